// File: hw/rtl/udfp_pkg.sv
// ----------------------------------------------------------------------------
// udfp_pkg
// shared types and constants of the usb debug frame parser: phase and result
// codes, marker and footer text, and the result item that flows front to back
// ----------------------------------------------------------------------------
package udfp_pkg;

   // widths of the result fields
   localparam int TypeW = 8;
   localparam int LenW  = 24;
   localparam int ByteW = 8;

   // result queue between front and back
   localparam int QDepth = 2;
   localparam int QIdxW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEAD,
      PH_DATA,
      PH_FOOT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_DATA,
      KIND_FOOT_GOOD,
      KIND_FOOT_BAD
   } kind_type;

   // "DMA@" and "CMPH", first character in the lowest byte
   localparam logic [3:0][7:0] MarkerText = {8'h40, 8'h41, 8'h4D, 8'h44};
   localparam logic [3:0][7:0] FooterText = {8'h48, 8'h50, 8'h4D, 8'h43};

   typedef struct packed {
      kind_type           kind;
      logic [TypeW-1:0]   frame_type;
      logic [LenW-1:0]    length;
      logic [ByteW-1:0]   data;
      logic               last;
   } rsp_item_type;

endpackage

// File: hw/rtl/usb_debug_frame_parser_core.sv
// ----------------------------------------------------------------------------
// usb_debug_frame_parser_core
// byte-serial deframer for a usb debug link: marker hunt, header, payload,
// footer check
// ----------------------------------------------------------------------------
// Takes one received byte per beat and sustains one byte per clock cycle while
// the result queue has room. It hunts for the text "DMA@", then reads a
// big-endian header word (type byte, 24-bit length) and reports it, passes that
// many payload bytes with tlast on the final one, then checks the four-byte
// "CMPH" footer and reports good or bad. Bytes between frames are dropped
// silently. The front classifies each byte in the cycle it is accepted; a
// result reaches rsp through the two-entry result queue and then the output
// register. A stalled result side fills the queue and only then holds off
// req_tready. Lengths wider than LEN_BITS saturate to all ones.
// ----------------------------------------------------------------------------
module usb_debug_frame_parser_core #(
   parameter int LEN_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_type, [31:8] out_length, [39:32] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast
);

   logic                   push_valid;
   logic                   push_ready;
   udfp_pkg::rsp_item_type push_item;
   logic                   pop_valid;
   logic                   pop_ready;
   udfp_pkg::rsp_item_type pop_item;

   udfp_front #(
      .LEN_BITS (LEN_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_ready    (push_ready),
      .q_valid    (push_valid),
      .q_item     (push_item)
   );

   udfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   udfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_ready    (pop_ready),
      .q_item     (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/udfp_front.sv
// ----------------------------------------------------------------------------
// udfp_front
// takes one received byte per beat, tracks hunt / header / payload / footer
// phase and builds the result item that a byte causes
// ----------------------------------------------------------------------------
module udfp_front #(
   parameter int LEN_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  q_ready,
   output logic                  q_valid,
   output udfp_pkg::rsp_item_type q_item
);

   udfp_pkg::phase_type   phase_ff, phase_in;
   logic [1:0]            match_ff, match_in;
   logic [7:0]            type_ff, type_in;
   logic [LEN_BITS-1:0]   left_ff, left_in;
   logic                  footer_ok_ff, footer_ok_in;

   logic                  accept;
   logic [LEN_BITS+7:0]   len_shl;
   logic [LEN_BITS-1:0]   len_new;
   logic                  len_sat;
   logic                  foot_ok_now;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;

   assign len_shl     = {left_ff, req_tdata};
   assign len_sat     = |left_ff[LEN_BITS-1 -: 8];
   assign foot_ok_now = footer_ok_ff && (req_tdata == udfp_pkg::FooterText[match_ff]);

   // gathered length after this header byte; type byte restarts it
   always_comb begin
      if (match_ff == 2'd0) begin
         len_new = '0;
      end else if (len_sat) begin
         len_new = '1;
      end else begin
         len_new = len_shl[LEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= udfp_pkg::PH_HUNT;
         match_ff     <= 2'd0;
         type_ff      <= 8'd0;
         left_ff      <= '0;
         footer_ok_ff <= 1'b1;
      end else if (accept) begin
         phase_ff     <= phase_in;
         match_ff     <= match_in;
         type_ff      <= type_in;
         left_ff      <= left_in;
         footer_ok_ff <= footer_ok_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      match_in     = match_ff;
      type_in      = type_ff;
      left_in      = left_ff;
      footer_ok_in = footer_ok_ff;
      q_valid      = 1'b0;
      q_item       = '0;
      unique case (phase_ff)
         udfp_pkg::PH_HUNT: begin
            if (req_tdata == udfp_pkg::MarkerText[match_ff]) begin
               if (match_ff == 2'd3) begin
                  phase_in = udfp_pkg::PH_HEAD;
                  match_in = 2'd0;
                  left_in  = '0;
                  type_in  = 8'd0;
               end else begin
                  match_in = match_ff + 2'd1;
               end
            end else begin
               // a broken partial match may itself start a new marker
               match_in = (req_tdata == udfp_pkg::MarkerText[0]) ? 2'd1 : 2'd0;
            end
         end
         udfp_pkg::PH_HEAD: begin
            left_in = len_new;
            if (match_ff == 2'd0) begin
               type_in = req_tdata;
            end
            if (match_ff != 2'd3) begin
               match_in = match_ff + 2'd1;
            end else begin
               q_valid           = accept;
               q_item.kind       = udfp_pkg::KIND_HEADER;
               q_item.frame_type = type_ff;
               q_item.length     = udfp_pkg::LenW'(len_new);
               match_in          = 2'd0;
               if (len_new == '0) begin
                  phase_in     = udfp_pkg::PH_FOOT;
                  footer_ok_in = 1'b1;
               end else begin
                  phase_in = udfp_pkg::PH_DATA;
               end
            end
         end
         udfp_pkg::PH_DATA: begin
            q_valid     = accept;
            q_item.kind = udfp_pkg::KIND_DATA;
            q_item.data = req_tdata;
            if (left_ff[LEN_BITS-1:1] == '0) begin
               q_item.last  = 1'b1;
               left_in      = '0;
               phase_in     = udfp_pkg::PH_FOOT;
               match_in     = 2'd0;
               footer_ok_in = 1'b1;
            end else begin
               left_in = left_ff - LEN_BITS'(1);
            end
         end
         udfp_pkg::PH_FOOT: begin
            footer_ok_in = foot_ok_now;
            if (match_ff != 2'd3) begin
               match_in = match_ff + 2'd1;
            end else begin
               q_valid      = accept;
               q_item.kind  = foot_ok_now ? udfp_pkg::KIND_FOOT_GOOD
                                          : udfp_pkg::KIND_FOOT_BAD;
               phase_in     = udfp_pkg::PH_HUNT;
               match_in     = 2'd0;
               footer_ok_in = 1'b1;
            end
         end
         default: begin
            phase_in = udfp_pkg::PH_HUNT;
         end
      endcase
   end

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == udfp_pkg::PH_DATA |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   a_hunt_footer_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == udfp_pkg::PH_HUNT |-> footer_ok_ff)
      else $error("footer flag left cleared while hunting");

   a_last_enters_footer: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_item.kind == udfp_pkg::KIND_DATA && q_item.last
      |=> phase_ff == udfp_pkg::PH_FOOT && match_ff == 2'd0)
      else $error("final payload byte did not move to footer");

endmodule

// File: hw/rtl/udfp_queue.sv
// ----------------------------------------------------------------------------
// udfp_queue
// short result queue that lets the front and the back stall independently
// ----------------------------------------------------------------------------
module udfp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  udfp_pkg::rsp_item_type push_item,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output udfp_pkg::rsp_item_type pop_item
);

   udfp_pkg::rsp_item_type         entry_ff [udfp_pkg::QDepth];
   logic [udfp_pkg::QIdxW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [udfp_pkg::QIdxW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [udfp_pkg::QCntW-1:0]     count_ff, count_in;
   logic                           push;
   logic                           pop;

   assign push_ready = count_ff != udfp_pkg::QCntW'(udfp_pkg::QDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == udfp_pkg::QIdxW'(udfp_pkg::QDepth - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == udfp_pkg::QIdxW'(udfp_pkg::QDepth - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/udfp_back.sv
// ----------------------------------------------------------------------------
// udfp_back
// output register of the result stream; packs a result item onto the bus
// ----------------------------------------------------------------------------
module udfp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  udfp_pkg::rsp_item_type q_item,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   logic                   vld_ff, vld_in;
   udfp_pkg::rsp_item_type item_ff;

   // register may reload whenever it is empty or being drained
   assign q_ready = !vld_ff || rsp_tready;
   assign vld_in  = q_ready ? q_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ready && q_valid) begin
         item_ff <= q_item;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {item_ff.data, item_ff.length, item_ff.frame_type};
   assign rsp_tuser  = item_ff.kind;
   assign rsp_tlast  = item_ff.last;

endmodule
